### design/iul_pkg.sv
// ----------------------------------------------------------------------------
// iul_pkg
// Shared constants and types for the interval union length block.
// ----------------------------------------------------------------------------
`default_nettype none

package iul_pkg;

    localparam int DEF_MAX_INTERVALS = 1024;
    localparam int COORD_W           = 32;
    localparam int LEN_W             = 32;
    localparam int ENTRY_W           = 2 * COORD_W;

    // control from the sequencer to the sweep accumulator
    typedef struct packed {
        logic init;   // first entry of a set: seed run end and total
        logic step;   // merge one further entry
    } sweep_ctl_t;

endpackage

`default_nettype wire

### design/iul_if.sv
// ----------------------------------------------------------------------------
// iul_if
// Valid/ready channels for interval transactions and length results.
// ----------------------------------------------------------------------------
`default_nettype none

interface iul_in_if
    import iul_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_req;
    logic signed [COORD_W-1:0] stop;
    logic                      last;

    modport source (output valid, start_req, stop, last, input ready);
    modport sink   (input valid, start_req, stop, last, output ready);
endinterface

interface iul_out_if
    import iul_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] covered_length;

    modport source (output valid, covered_length, input ready);
    modport sink   (input valid, covered_length, output ready);
endinterface

`default_nettype wire

### design/iul_mem.sv
// ----------------------------------------------------------------------------
// iul_mem
// Interval store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iul_mem
    import iul_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_INTERVALS,
    parameter int AW    = $clog2(DEF_MAX_INTERVALS)
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [ENTRY_W-1:0] wdata,
    input  wire logic [AW-1:0]      raddr,
    output logic      [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/iul_sweep.sv
// ----------------------------------------------------------------------------
// iul_sweep
// Merge accumulator: walks sorted intervals and sums the covered length.
// ----------------------------------------------------------------------------
`default_nettype none

module iul_sweep
    import iul_pkg::*;
#(
    parameter int TOT_W = COORD_W + 13
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sweep_ctl_t                ctl,
    input  wire logic signed [COORD_W-1:0] s,
    input  wire logic signed [COORD_W-1:0] e,
    output logic             [LEN_W-1:0]   length
);

    logic signed [COORD_W-1:0] run_end_reg, run_end_next;
    logic signed [TOT_W-1:0]   total_reg, total_next;
    logic signed [TOT_W-1:0]   s_x, e_x, r_x, span;

    assign s_x  = TOT_W'(s);
    assign e_x  = TOT_W'(e);
    assign r_x  = TOT_W'(run_end_reg);
    assign span = e_x - s_x;

    always_comb
    begin
        run_end_next = run_end_reg;
        total_next   = total_reg;
        if (ctl.init)
        begin
            // seed plus the merge of entry zero against itself
            run_end_next = e;
            total_next   = (s > e) ? (span + span) : span;
        end
        else if (ctl.step)
        begin
            if (s > run_end_reg)
            begin
                run_end_next = e;
                total_next   = total_reg + span;
            end
            else if (e > run_end_reg)
            begin
                run_end_next = e;
                total_next   = total_reg + (e_x - r_x);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_end_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            run_end_reg <= run_end_next;
            total_reg   <= total_next;
        end
    end

    // clamp to the unsigned result range
    always_comb
    begin
        if (total_reg[TOT_W-1])
        begin
            length = '0;
        end
        else if (|total_reg[TOT_W-2:LEN_W])
        begin
            length = '1;
        end
        else
        begin
            length = total_reg[LEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/interval_union_length_top.sv
// ----------------------------------------------------------------------------
// interval_union_length_top
// Length of the union of a set of closed intervals.
// ----------------------------------------------------------------------------
// Intervals of a set arrive one per transaction, the one with last set closes
// the set, and one covered_length transaction follows. Each interval is put in
// start order as it arrives (stable insertion into the store): the first of its
// set is written directly, and a later one is placed after every stored entry
// with a larger start has been shifted up one place, each shift going through
// the store's one read port and one write port. Closing a set adds a sweep over
// the N stored entries through the merge accumulator. Intervals beyond
// MAX_INTERVALS in a set are dropped. A result may wait at the output while the
// next set loads.
`default_nettype none

module interval_union_length_top
    import iul_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    iul_in_if.sink    req,
    iul_out_if.source rsp
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int AW    = $clog2(MAX_INTERVALS);
    localparam int TOT_W = COORD_W + CNT_W + 2;
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_INTERVALS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INS,
        ST_PUT,
        ST_SWEEP
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic signed [COORD_W-1:0] s_reg, s_next, e_reg, e_next;
    logic last_reg, last_next;
    logic rvld_reg, rvld_next;
    logic first_reg, first_next;
    logic out_valid_reg, out_valid_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [CNT_W-1:0]   cnt_m1, j_m1, j_m2;
    logic signed [COORD_W-1:0] rd_start;
    logic [LEN_W-1:0]   sweep_len;
    sweep_ctl_t         ctl;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign j_m1     = j_reg - CNT_W'(1);
    assign j_m2     = j_reg - CNT_W'(2);
    assign rd_start = rdata[ENTRY_W-1:COORD_W];

    assign req.ready          = (state_reg == ST_LOAD);
    assign rsp.valid          = out_valid_reg;
    assign rsp.covered_length = len_reg;

    iul_mem #(.DEPTH(MAX_INTERVALS), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    iul_sweep #(.TOT_W(TOT_W)) u_sweep (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .s      (rd_start),
        .e      (rdata[COORD_W-1:0]),
        .length (sweep_len)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        last_next      = last_reg;
        rvld_next      = rvld_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        len_next       = len_reg;
        we             = 1'b0;
        waddr          = j_reg[AW-1:0];
        wdata          = {s_reg, e_reg};
        raddr          = '0;
        ctl            = '0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (req.valid)
                begin
                    s_next    = req.start_req;
                    e_next    = req.stop;
                    last_next = req.last;
                    if (count_reg == MAX_C || count_reg == '0)
                    begin
                        if (count_reg == '0)
                        begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = {req.start_req, req.stop};
                            count_next = CNT_W'(1);
                        end
                        if (req.last)
                        begin
                            i_next     = '0;
                            rvld_next  = 1'b0;
                            first_next = 1'b1;
                            state_next = ST_SWEEP;
                        end
                    end
                    else
                    begin
                        j_next     = count_reg;
                        raddr      = cnt_m1[AW-1:0];
                        state_next = ST_INS;
                    end
                end
            end

            ST_INS, ST_PUT:
            begin
                we = 1'b1;
                if (state_reg == ST_INS && rd_start > s_reg)
                begin
                    // shift the larger entry up one place
                    wdata  = rdata;
                    j_next = j_m1;
                    if (j_m1 == '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        raddr = j_m2[AW-1:0];
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (last_reg)
                    begin
                        i_next     = '0;
                        rvld_next  = 1'b0;
                        first_next = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_SWEEP:
            begin
                rvld_next = 1'b0;
                if (i_reg != count_reg)
                begin
                    raddr     = i_reg[AW-1:0];
                    i_next    = i_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                end
                if (rvld_reg)
                begin
                    ctl.init   = first_reg;
                    ctl.step   = !first_reg;
                    first_next = 1'b0;
                end
                else if (i_reg == count_reg && (!out_valid_reg || rsp.ready))
                begin
                    out_valid_next = 1'b1;
                    len_next       = sweep_len;
                    count_next     = '0;
                    state_next     = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            j_reg         <= '0;
            i_reg         <= '0;
            s_reg         <= '0;
            e_reg         <= '0;
            last_reg      <= 1'b0;
            rvld_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            i_reg         <= i_next;
            s_reg         <= s_next;
            e_reg         <= e_next;
            last_reg      <= last_next;
            rvld_reg      <= rvld_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("entry count above store depth");

    a_ins_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS |-> j_reg != '0 && j_reg <= count_reg)
        else $error("insertion index out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(len_reg))
        else $error("pending result lost or changed");

    a_sweep_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> i_reg <= count_reg)
        else $error("sweep ran past stored entries");
`endif

endmodule

`default_nettype wire
